FILE: rtl/crm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_pkg - shared types and constants of the cyclic rotation matcher
// Field widths, default sizes and the control group handed to the cell array.
// ----------------------------------------------------------------------------
package crm_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int MAX_TEXT_DEF    = 1048576;

    localparam int SYM_W     = 8;
    localparam int POS_W     = 20;
    localparam int CNT_W     = 21;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    typedef logic [SYM_W-1:0] sym_t;

    typedef struct packed {
        logic pat_we;
        logic run_en;
        logic restart;
    } crm_ctrl_t;

endpackage

FILE: rtl/crm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_cell - one match-run cell
// Holds the length of the longest text suffix ending on this cell's pattern
// byte, fed by the run of the left neighbor; flags a full-length run.
// ----------------------------------------------------------------------------
module crm_cell #(
    parameter int LEN_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              restart,
    input  crm_pkg::sym_t     sym,
    input  crm_pkg::sym_t     pat,
    input  logic [LEN_W-1:0]  prev,
    input  logic [LEN_W-1:0]  plen,
    output logic [LEN_W-1:0]  run,
    output logic              full
);
    import crm_pkg::*;

    logic [LEN_W-1:0] run_reg, run_next;
    logic             full_reg, full_next;
    logic [LEN_W:0]   inc;

    always_comb begin
        inc       = {1'b0, (restart ? {LEN_W{1'b0}} : prev)} + (LEN_W+1)'(1);
        run_next  = run_reg;
        full_next = full_reg;
        if (en) begin
            if (sym == pat) begin
                run_next = (inc > {1'b0, plen}) ? plen : inc[LEN_W-1:0];
            end else begin
                run_next = '0;
            end
            full_next = (run_next == plen);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= '0;
            full_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            full_reg <= full_next;
        end
    end

    assign run  = run_reg;
    assign full = full_reg;

endmodule

FILE: rtl/crm_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_array - pattern store and the row of match-run cells
// Lower row follows the pattern, upper row follows its wrapped copy; the
// upper row is entered from the lower cell at the pattern's last byte.
// ----------------------------------------------------------------------------
module crm_array #(
    parameter  int MAX_PATTERN = crm_pkg::MAX_PATTERN_DEF,
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1),
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  crm_pkg::crm_ctrl_t  ctrl,
    input  crm_pkg::sym_t       sym,
    input  logic [IDX_W-1:0]    pat_addr,
    input  logic [LEN_W-1:0]    plen,
    output logic                hit
);
    import crm_pkg::*;

    sym_t             pat_reg [MAX_PATTERN];
    logic [LEN_W-1:0] run_lo  [MAX_PATTERN];
    logic [LEN_W-1:0] prev_lo [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] full_lo;
    logic [MAX_PATTERN-1:0] hit_lo;
    logic [IDX_W-1:0] lo_sel;
    logic             hi_any;

    always_ff @(posedge aclk) begin
        if (ctrl.pat_we) begin
            pat_reg[pat_addr] <= sym;
        end
    end

    assign lo_sel = (plen == '0) ? '0 : IDX_W'(plen - LEN_W'(1));

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lo
        if (j == 0) begin : g_first
            assign prev_lo[j] = '0;
        end else begin : g_next
            assign prev_lo[j] = run_lo[j-1];
        end

        crm_cell #(.LEN_W(LEN_W)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (ctrl.run_en),
            .restart (ctrl.restart),
            .sym     (sym),
            .pat     (pat_reg[j]),
            .prev    (prev_lo[j]),
            .plen    (plen),
            .run     (run_lo[j]),
            .full    (full_lo[j])
        );

        assign hit_lo[j] = full_lo[j] && (plen == LEN_W'(j + 1));
    end

    if (MAX_PATTERN > 1) begin : g_hi
        logic [LEN_W-1:0]       run_hi  [MAX_PATTERN-1];
        logic [LEN_W-1:0]       prev_hi [MAX_PATTERN-1];
        logic [MAX_PATTERN-2:0] full_hi;
        logic [MAX_PATTERN-2:0] hit_hi;

        for (genvar k = 0; k < MAX_PATTERN - 1; k++) begin : g_cell
            if (k == 0) begin : g_first
                assign prev_hi[k] = run_lo[lo_sel];
            end else begin : g_next
                assign prev_hi[k] = run_hi[k-1];
            end

            crm_cell #(.LEN_W(LEN_W)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (ctrl.run_en),
                .restart (ctrl.restart),
                .sym     (sym),
                .pat     (pat_reg[k]),
                .prev    (prev_hi[k]),
                .plen    (plen),
                .run     (run_hi[k]),
                .full    (full_hi[k])
            );

            assign hit_hi[k] = full_hi[k] && ({1'b0, plen} >= (LEN_W+1)'(k + 2));
        end

        assign hi_any = |hit_hi;
    end else begin : g_no_hi
        assign hi_any = 1'b0;
    end

    assign hit = (|hit_lo) | hi_any;

endmodule

FILE: rtl/cyclic_rotation_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_rotation_matcher_top - pattern rotation search over a byte stream
// Input stream: s_tuser selects pattern byte (0) or text byte (1), s_tdata
// carries the byte, s_tlast ends the pattern or the text. Pattern bytes past
// MAX_PATTERN are dropped and flagged. After each text byte the block checks
// whether the last P text bytes are a rotation of the P-byte pattern.
// Output stream: m_tuser is 0 for a match position, 1 for the end-of-text
// summary with the match count; m_tlast marks the last transfer of a byte.
// Flow: a pattern byte is accepted in the idle state, which it does not leave.
// A text byte updates every match-run cell in the accept cycle, the hit is
// resolved over the cell row in the next cycle and the first result appears
// in the cycle after that. Input waits until every result of a byte is taken;
// a stalled m_tready holds the result and keeps s_tready low. Reset clears the
// state, length, overflow/open/in-text flags, match runs, counters and m_tvalid.
// ----------------------------------------------------------------------------
module cyclic_rotation_matcher_top #(
    parameter  int MAX_PATTERN = crm_pkg::MAX_PATTERN_DEF,
    parameter  int MAX_TEXT    = crm_pkg::MAX_TEXT_DEF,
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1),
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [crm_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] symbol
    input  logic                          s_tuser,   // [0] cmd
    input  logic                          s_tlast,   // is_final
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [crm_pkg::M_TDATA_W-1:0] m_tdata,   // [19:0] position,
                                                     // [40:20] match_count,
                                                     // [41] pattern_overflow
    output logic                          m_tuser,   // [0] is_summary
    output logic                          m_tlast    // last
);
    import crm_pkg::*;

    localparam logic [CNT_W-1:0] COUNT_CAP =
        CNT_W'((MAX_TEXT < (1 << POS_W)) ? MAX_TEXT : (1 << POS_W));
    localparam logic [CNT_W-1:0] POS_CAP = COUNT_CAP - CNT_W'(1);
    localparam int               PAD_W   = M_TDATA_W - POS_W - CNT_W - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_POS,
        ST_SUM
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             open_reg, open_next;
    logic             in_text_reg, in_text_next;
    logic [CNT_W-1:0] tp_reg, tp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             fin_reg, fin_next;
    logic [POS_W-1:0] cand_reg, cand_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_sum_reg, m_sum_next;
    logic [POS_W-1:0] m_pos_reg, m_pos_next;
    logic [CNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic             m_ovf_reg, m_ovf_next;
    logic             m_last_reg, m_last_next;

    logic             s_fire, pat_fire, txt_fire;
    logic [LEN_W-1:0] len_eff;
    logic [CNT_W-1:0] tp_eff;
    logic [CNT_W:0]   tp_inc;
    logic [CNT_W:0]   cand_full;
    logic             hit;
    crm_ctrl_t        ctrl;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign pat_fire = s_fire && !s_tuser;
    assign txt_fire = s_fire && s_tuser;

    assign len_eff = open_reg ? len_reg : '0;
    assign tp_eff  = in_text_reg ? tp_reg : '0;
    assign tp_inc  = {1'b0, tp_eff} + (CNT_W+1)'(1);

    always_comb begin
        cand_full = '0;
        if (tp_inc >= (CNT_W+1)'(len_reg)) begin
            cand_full = tp_inc - (CNT_W+1)'(len_reg);
        end
        if (cand_full > {1'b0, POS_CAP}) begin
            cand_full = {1'b0, POS_CAP};
        end
    end

    assign ctrl.pat_we  = pat_fire && (len_eff < LEN_W'(MAX_PATTERN));
    assign ctrl.run_en  = txt_fire;
    assign ctrl.restart = !in_text_reg;

    crm_array #(.MAX_PATTERN(MAX_PATTERN)) u_array (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sym      (s_tdata[SYM_W-1:0]),
        .pat_addr (IDX_W'(len_eff)),
        .plen     (len_reg),
        .hit      (hit)
    );

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        open_next    = open_reg;
        in_text_next = in_text_reg;
        tp_next      = tp_reg;
        cnt_next     = cnt_reg;
        fin_next     = fin_reg;
        cand_next    = cand_reg;
        m_valid_next = m_valid_reg;
        m_sum_next   = m_sum_reg;
        m_pos_next   = m_pos_reg;
        m_cnt_next   = m_cnt_reg;
        m_ovf_next   = m_ovf_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (pat_fire) begin
                    open_next    = !s_tlast;
                    in_text_next = 1'b0;
                    if (len_eff < LEN_W'(MAX_PATTERN)) begin
                        len_next = len_eff + LEN_W'(1);
                        ovf_next = open_reg ? ovf_reg : 1'b0;
                    end else begin
                        len_next = len_eff;
                        ovf_next = 1'b1;
                    end
                end else if (txt_fire) begin
                    open_next    = 1'b0;
                    in_text_next = !s_tlast;
                    tp_next      = (tp_eff < COUNT_CAP) ? tp_inc[CNT_W-1:0] : tp_eff;
                    cnt_next     = in_text_reg ? cnt_reg : '0;
                    fin_next     = s_tlast;
                    cand_next    = cand_full[POS_W-1:0];
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL: begin
                m_ovf_next = ovf_reg;
                if (hit) begin
                    cnt_next     = (cnt_reg < COUNT_CAP) ? cnt_reg + CNT_W'(1) : cnt_reg;
                    m_valid_next = 1'b1;
                    m_sum_next   = 1'b0;
                    m_pos_next   = cand_reg;
                    m_cnt_next   = cnt_next;
                    m_last_next  = !fin_reg;
                    state_next   = ST_POS;
                end else if (fin_reg) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = 1'b1;
                    m_pos_next   = '0;
                    m_cnt_next   = cnt_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_SUM;
                end else begin
                    state_next   = ST_IDLE;
                end
            end
            ST_POS: begin
                if (m_tready) begin
                    if (fin_reg) begin
                        m_sum_next  = 1'b1;
                        m_pos_next  = '0;
                        m_cnt_next  = cnt_reg;
                        m_last_next = 1'b1;
                        state_next  = ST_SUM;
                    end else begin
                        m_valid_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_SUM: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            open_reg    <= 1'b0;
            in_text_reg <= 1'b0;
            tp_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            open_reg    <= open_next;
            in_text_reg <= in_text_next;
            tp_reg      <= tp_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        fin_reg    <= fin_next;
        cand_reg   <= cand_next;
        m_sum_reg  <= m_sum_next;
        m_pos_reg  <= m_pos_next;
        m_cnt_reg  <= m_cnt_next;
        m_ovf_reg  <= m_ovf_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_ovf_reg, m_cnt_reg, m_pos_reg};
    assign m_tuser  = m_sum_reg;
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("summary transfer without tlast");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= COUNT_CAP) && (tp_reg <= COUNT_CAP))
        else $error("counter beyond saturation limit");

    a_match_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_cnt_reg != '0))
        else $error("match reported with zero count");

    a_eval_after_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> $past(txt_fire))
        else $error("evaluation without a text transfer");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for cyclic_rotation_matcher_top
// Streams patterns and texts into the matcher and tracks the expected match
// positions and end-of-text summaries with a cycle-free software predictor.
// Every result transfer is checked field by field against the oldest
// expectation. Random idle gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module tb;

    import crm_pkg::*;

    localparam int MAX_PAT        = MAX_PATTERN_DEF;
    localparam int POS_CAP        = (1 << POS_W) - 1;
    localparam int COUNT_CAP      = 1 << POS_W;
    localparam int ITEM_TARGET    = 1050;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic CMD_PATTERN  = 1'b0;
    localparam logic CMD_TEXT     = 1'b1;
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic cmd;
        sym_t sym;
        logic fin;
        logic drain;
    } feed_item_t;

    typedef struct packed {
        logic             summary;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        logic             ovf;
        logic             last;
    } match_res_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    feed_item_t byte_feed_q[$];
    match_res_t match_expect_q[$];
    feed_item_t tx_cur;
    int         total_items  = 0;
    int         accepted_cnt = 0;
    int         errors       = 0;
    int         tx_gap       = 0;
    int         tx_idle_mode = 0;
    int         rx_hold      = 0;
    int         rx_idle_mode = 0;
    int         rx_cycles    = 0;
    int         idle_cycles  = 0;

    // predictor state
    sym_t pat_mem [MAX_PAT];
    int   pat_len  = 0;
    int   run_len [2*MAX_PAT];
    int   text_idx = 0;
    int   hits     = 0;
    bit   ovf      = 1'b0;
    bit   in_text  = 1'b0;
    bit   pat_open = 1'b0;

    cyclic_rotation_matcher_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_idle(int mode);
        int r;
        r = $urandom_range(99);
        if (mode == 0) return 0;
        if (mode == 1 && r < 85) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    function automatic void push_item(logic cmd, sym_t sym, logic fin, logic drain);
        feed_item_t it;
        it.cmd   = cmd;
        it.sym   = sym;
        it.fin   = fin;
        it.drain = drain;
        byte_feed_q.push_back(it);
        total_items++;
    endfunction

    // Updates the run cells over the doubled pattern and queues the results.
    task automatic predict_matches(input feed_item_t it);
        match_res_t r;
        bit         hit;
        int         j;
        int         idx;
        int         v;
        int         pos;
        begin
            if (it.cmd == CMD_PATTERN) begin
                if (!pat_open) begin
                    pat_len  = 0;
                    ovf      = 1'b0;
                    pat_open = 1'b1;
                end
                in_text = 1'b0;
                if (pat_len < MAX_PAT) begin
                    pat_mem[pat_len] = it.sym;
                    pat_len++;
                end else begin
                    ovf = 1'b1;
                end
                if (it.fin) pat_open = 1'b0;
            end else begin
                pat_open = 1'b0;
                if (!in_text) begin
                    foreach (run_len[k]) run_len[k] = 0;
                    text_idx = 0;
                    hits     = 0;
                    in_text  = 1'b1;
                end
                hit = 1'b0;
                if (pat_len != 0) begin
                    for (j = 2*pat_len - 2; j >= 0; j--) begin
                        idx = (j < pat_len) ? j : j - pat_len;
                        v   = 0;
                        if (pat_mem[idx] == it.sym) begin
                            v = ((j > 0) ? run_len[j-1] : 0) + 1;
                            if (v > pat_len) v = pat_len;
                        end
                        run_len[j] = v;
                        if (v == pat_len && j >= pat_len - 1) hit = 1'b1;
                    end
                end
                if (hit) begin
                    pos = (text_idx + 1 >= pat_len) ? text_idx + 1 - pat_len : 0;
                    if (pos > POS_CAP) pos = POS_CAP;
                    if (hits < COUNT_CAP) hits++;
                    r.summary = KIND_MATCH;
                    r.pos     = POS_W'(pos);
                    r.cnt     = CNT_W'(hits);
                    r.ovf     = ovf;
                    r.last    = !it.fin;
                    match_expect_q.push_back(r);
                end
                if (text_idx < COUNT_CAP) text_idx++;
                if (it.fin) begin
                    r.summary = KIND_SUMMARY;
                    r.pos     = '0;
                    r.cnt     = CNT_W'(hits);
                    r.ovf     = ovf;
                    r.last    = 1'b1;
                    match_expect_q.push_back(r);
                    in_text = 1'b0;
                end
            end
        end
    endtask

    function automatic void compare_field(string name, longint unsigned exp_v,
                                          longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // stimulus
    initial begin
        sym_t pat [80];
        sym_t txt [256];
        sym_t alpha [4];
        int   seq;
        int   n_pat;
        int   stored;
        int   alpha_n;
        int   n_texts;
        int   txt_len;
        int   k;
        int   r;
        int   rot;
        bit   noise;
        bit   fin_pat;
        bit   drain;
        bit   broken;

        // text with no pattern yet: empty pattern, summary only
        push_item(CMD_TEXT, 8'h41, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'h42, 1'b1, 1'b0);
        // three-byte pattern, two rotations found, last byte also ends text
        push_item(CMD_PATTERN, 8'h00, 1'b0, 1'b0);
        push_item(CMD_PATTERN, 8'hFF, 1'b0, 1'b0);
        push_item(CMD_PATTERN, 8'h5A, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'hFF, 1'b0, 1'b1);
        push_item(CMD_TEXT, 8'h5A, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'h00, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'hFF, 1'b1, 1'b0);
        // text shorter than the pattern
        push_item(CMD_TEXT, 8'h00, 1'b1, 1'b0);
        // open single-byte pattern closed by text
        push_item(CMD_PATTERN, 8'h41, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'h41, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'h41, 1'b1, 1'b0);
        // text interrupted by a new pattern
        push_item(CMD_TEXT, 8'h41, 1'b0, 1'b0);
        push_item(CMD_PATTERN, 8'h33, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'h33, 1'b1, 1'b1);
        // pattern final, then a fresh pattern replaces it
        push_item(CMD_PATTERN, 8'h80, 1'b1, 1'b0);
        push_item(CMD_PATTERN, 8'h7F, 1'b0, 1'b0);
        push_item(CMD_PATTERN, 8'h80, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'h80, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'h7F, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'h80, 1'b1, 1'b0);

        seq = 0;
        while (total_items < ITEM_TARGET) begin
            seq++;
            if (seq == 1) n_pat = MAX_PAT;
            else if (seq == 2) n_pat = MAX_PAT + 2;
            else if ($urandom_range(9) == 0) n_pat = $urandom_range(70, 9);
            else n_pat = $urandom_range(8, 1);
            alpha_n = $urandom_range(4, 1);
            for (k = 0; k < alpha_n; k++) alpha[k] = SYM_W'($urandom);
            noise   = ($urandom_range(9) == 0);
            fin_pat = ($urandom_range(9) != 0);
            drain   = (seq % 40 == 5);
            for (k = 0; k < n_pat; k++) begin
                pat[k] = alpha[$urandom_range(alpha_n - 1)];
                push_item(CMD_PATTERN, pat[k], fin_pat && k == n_pat - 1, drain && k == 0);
            end
            stored  = (n_pat < MAX_PAT) ? n_pat : MAX_PAT;
            n_texts = ($urandom_range(9) < 7) ? 1 : $urandom_range(3, 2);
            for (int t = 0; t < n_texts && total_items < ITEM_TARGET; t++) begin
                txt_len = $urandom_range(3*stored + 4, 1);
                if (txt_len > ITEM_TARGET - total_items) txt_len = ITEM_TARGET - total_items;
                k = 0;
                while (k < txt_len) begin
                    r = $urandom_range(99);
                    if (noise) begin
                        txt[k] = SYM_W'($urandom);
                        k++;
                    end else if (r < 70) begin
                        rot = $urandom_range(stored - 1);
                        for (int m = 0; m < stored && k < txt_len; m++) begin
                            txt[k] = pat[(rot + m) % stored];
                            k++;
                        end
                    end else begin
                        txt[k] = alpha[$urandom_range(alpha_n - 1)];
                        k++;
                    end
                end
                broken = ($urandom_range(9) == 0);
                for (k = 0; k < txt_len; k++)
                    push_item(CMD_TEXT, txt[k], !broken && k == txt_len - 1, 1'b0);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < total_items) @(posedge aclk);
        while (match_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_matches(tx_cur);
                accepted_cnt++;
                if (accepted_cnt % 64 == 0) tx_idle_mode = $urandom_range(2);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (byte_feed_q.size() != 0 &&
                             !(byte_feed_q[0].drain && match_expect_q.size() != 0)) begin
                    tx_cur = byte_feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= tx_cur.cmd;
                    s_tdata  <= tx_cur.sym;
                    s_tlast  <= tx_cur.fin;
                    tx_gap = pick_idle(tx_idle_mode);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        match_res_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (match_expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual tuser %0h tdata %0h",
                             $time, m_tuser, m_tdata);
                    errors++;
                end else begin
                    e = match_expect_q.pop_front();
                    compare_field("is_summary", 64'(e.summary), 64'(m_tuser));
                    compare_field("position", 64'(e.pos), 64'(m_tdata[POS_W-1:0]));
                    compare_field("match_count", 64'(e.cnt),
                                  64'(m_tdata[POS_W+CNT_W-1:POS_W]));
                    compare_field("pattern_overflow", 64'(e.ovf),
                                  64'(m_tdata[POS_W+CNT_W]));
                    compare_field("tdata pad", 64'(0),
                                  64'(m_tdata[M_TDATA_W-1:POS_W+CNT_W+1]));
                    compare_field("last", 64'(e.last), 64'(m_tlast));
                end
            end
            rx_cycles++;
            if (rx_cycles % 256 == 0) rx_idle_mode = $urandom_range(2);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_hold = pick_idle(rx_idle_mode);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
